// ===== hw/rtl/rdf_pkg.sv =====
`timescale 1ns / 1ps
package rdf_pkg;
    localparam int VALUE_BITS_DEF = 64;
    localparam int CELL_COUNT = 64;
    localparam int CELL_AW = 6;
    localparam logic [6:0] CAP_LIMIT = 7'd64;
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] DECIMAL_SPAN = 6'd10;
    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A = 7'h41;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BAD_RADIX = 2'd1,
        ST_NO_ROOM = 2'd2
    } t_status;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  radix;
        logic [6:0]  capacity;
    } t_req;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       is_last;
        logic [1:0] status;
        logic [6:0] length;
    } t_rsp;

    // classified job passed from front to back
    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  radix;
        logic [6:0]  cap;
        logic        bad_radix;
    } t_job;

    function automatic logic [6:0] to_ascii(input logic [5:0] d);
        logic [6:0] r;
        if (d < DECIMAL_SPAN) r = ASCII_ZERO + {1'b0, d};
        else r = ASCII_A + {1'b0, d - DECIMAL_SPAN};
        return r;
    endfunction
endpackage

// ===== hw/rtl/radix_digit_formatter.sv =====
`timescale 1ns / 1ps
// Channel  | handshake          | payload
// request  | i_valid / o_ready  | i_req  (value, radix, capacity)
// response | o_valid / i_ready  | o_rsp  (digit_char, is_last, status, length)
//
// Each digit comes out of the bit-serial divider (shift states, then a store
// state); each character then takes a cell read and an output register.
// A bad radix result is registered at the edge that takes its job off the
// queue; a capacity error waits for the full division.
// Reset clears control state; digit cells are never cleared.
// A two-entry request queue keeps accepting while the back end stalls, until full.
module radix_digit_formatter #(
    parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rdf_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output rdf_pkg::t_rsp o_rsp
);
    import rdf_pkg::*;

    t_job w_job;
    logic w_job_valid, w_job_ready;

    // front: mask value, saturate capacity, check radix, queue the request
    rdf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    // back: divide into digit cells, then emit most significant first
    rdf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_valid, .i_ready, .o_rsp
    );
endmodule

// ===== hw/rtl/rdf_front.sv =====
`timescale 1ns / 1ps
module rdf_front #(
    parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rdf_pkg::t_req  i_req,
    output logic           o_job_valid,
    input  logic           i_job_ready,
    output rdf_pkg::t_job  o_job
);
    import rdf_pkg::*;

    // two-entry queue
    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       w_push, w_pop;
    logic [63:0] w_mask;

    assign w_mask = {64{1'b1}} >> (64 - VALUE_BITS);

    always_comb begin
        w_job.value = i_req.value & w_mask;
        w_job.radix = i_req.radix;
        w_job.cap = (i_req.capacity > CAP_LIMIT) ? CAP_LIMIT : i_req.capacity;
        w_job.bad_radix = (i_req.radix < RADIX_MIN) || (i_req.radix > RADIX_MAX);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop = o_job_valid && i_job_ready;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_q[r_wp] <= w_job;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("bad queue count");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> $past(r_cnt) != 2'd0 || $past(w_push)) else $error("pop empty");
`endif
endmodule

// ===== hw/rtl/rdf_back.sv =====
`timescale 1ns / 1ps
module rdf_back #(
    parameter int VALUE_BITS = rdf_pkg::VALUE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  rdf_pkg::t_job  i_job,
    output logic           o_valid,
    input  logic           i_ready,
    output rdf_pkg::t_rsp  o_rsp
);
    import rdf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_STORE, S_CHECK, S_READ, S_EMIT
    } t_state;

    localparam int CW = $clog2(VALUE_BITS + 1);

    t_state       r_state;
    logic [63:0]  r_val;      // quotient being built bit by bit
    logic [5:0]   r_rem;
    logic [5:0]   r_radix;
    logic [6:0]   r_cap;
    logic [CW-1:0] r_bit;
    logic [6:0]   r_count;
    logic [6:0]   r_emit;
    logic [5:0]   r_rd;
    logic [5:0]   r_cells [CELL_COUNT];
    logic         r_ov;
    t_rsp         r_rsp;
    logic [6:0]   w_trial;
    logic         w_ge;
    logic         w_slot;

    // restoring long division, one quotient bit per cycle
    assign w_trial = {r_rem, r_val[VALUE_BITS-1]};
    assign w_ge = (w_trial >= {1'b0, r_radix});
    assign o_job_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_rsp = r_rsp;
    assign w_slot = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov <= 1'b0;
            r_count <= 7'd0;
            r_emit <= 7'd0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid && !r_ov) begin
                        if (i_job.bad_radix) begin
                            r_rsp <= '{7'd0, 1'b1, ST_BAD_RADIX, 7'd0};
                            r_ov <= 1'b1;
                        end else begin
                            r_val <= i_job.value;
                            r_radix <= i_job.radix;
                            r_cap <= i_job.cap;
                            r_rem <= 6'd0;
                            r_bit <= CW'(VALUE_BITS);
                            r_count <= 7'd0;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    r_rem <= w_ge ? 6'(w_trial - {1'b0, r_radix}) : w_trial[5:0];
                    r_val <= {r_val[62:0], w_ge};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == CW'(1)) r_state <= S_STORE;
                end
                S_STORE: begin
                    // write digit; quotient now in the low VALUE_BITS of r_val
                    r_cells[r_count[5:0]] <= r_rem;
                    r_count <= r_count + 7'd1;
                    if (r_val[VALUE_BITS-1:0] == '0 || r_count == 7'd63) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_rem <= 6'd0;
                        r_bit <= CW'(VALUE_BITS);
                        r_state <= S_SHIFT;
                    end
                end
                S_CHECK: begin
                    if (!r_ov) begin
                        if (r_count > r_cap) begin
                            r_rsp <= '{7'd0, 1'b1, ST_NO_ROOM, 7'd0};
                            r_ov <= 1'b1;
                            r_count <= 7'd0;
                            r_state <= S_IDLE;
                        end else begin
                            r_emit <= 7'd0;
                            r_rd <= 6'(r_count - 7'd1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_rem <= r_cells[r_rd];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_rsp.digit_char <= to_ascii(r_rem);
                        r_rsp.is_last <= (r_emit + 7'd1 == r_count);
                        r_rsp.status <= ST_OK;
                        r_rsp.length <= r_count;
                        r_ov <= 1'b1;
                        r_emit <= r_emit + 7'd1;
                        r_rd <= r_rd - 6'd1;
                        r_state <= (r_emit + 7'd1 == r_count) ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp)) else $error("rsp dropped");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_emit < r_count) else $error("emit past count");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_count <= r_cap && r_count != 7'd0)
        else $error("count over cap");
`endif
endmodule

// ===== sim/radix_digit_formatter_tb.sv =====
`timescale 1ns / 1ps
module radix_digit_formatter_tb;
    import rdf_pkg::*;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_req  i_req;
    logic  o_valid;
    logic  i_ready;
    t_rsp  o_rsp;

    // expected characters, oldest first
    t_rsp  digit_queue[$];
    int    error_count;
    int    cycle_count;

    localparam int CYCLE_LIMIT = 10000000;

    radix_digit_formatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Work out the characters for one request and queue them.
    task automatic predict_digits(input t_req r);
        logic [63:0] v;
        logic [6:0]  cap;
        logic [5:0]  cells[64];
        logic [5:0]  d;
        int          count;
        t_rsp        e;
        v = r.value;
        cap = (r.capacity > CAP_LIMIT) ? CAP_LIMIT : r.capacity;
        count = 0;
        if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
            e = '{digit_char: 7'd0, is_last: 1'b1, status: ST_BAD_RADIX, length: 7'd0};
            digit_queue.push_back(e);
            return;
        end
        if (v == 64'd0) begin
            cells[0] = 6'd0;
            count = 1;
        end else begin
            while (v != 64'd0 && count < 64) begin
                cells[count] = 6'(v % r.radix);
                v = v / r.radix;
                count++;
            end
        end
        if (count > cap) begin
            e = '{digit_char: 7'd0, is_last: 1'b1, status: ST_NO_ROOM, length: 7'd0};
            digit_queue.push_back(e);
            return;
        end
        for (int k = 0; k < count; k++) begin
            d = cells[count - 1 - k];
            e.digit_char = (d < DECIMAL_SPAN) ? ASCII_ZERO + 7'(d)
                                              : ASCII_A + 7'(d - DECIMAL_SPAN);
            e.is_last = (k == count - 1);
            e.status = ST_OK;
            e.length = 7'(count);
            digit_queue.push_back(e);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // Send one request after a random gap; hold until accepted.
    task automatic send_request(input logic [63:0] value, input logic [5:0] radix,
                                input logic [6:0] capacity);
        t_req r;
        int   gap;
        gap = $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        r = '{value: value, radix: radix, capacity: capacity};
        i_req <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_digits(r);
        @(negedge i_clk);
    endtask

    // Random stall on the response side, drawn per character.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compare each accepted character with the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (digit_queue.size() == 0) begin
                report_mismatch("unexpected response");
            end else begin
                e = digit_queue.pop_front();
                if (o_rsp.digit_char !== e.digit_char)
                    report_mismatch($sformatf("digit_char %0h want %0h",
                                              o_rsp.digit_char, e.digit_char));
                if (o_rsp.is_last !== e.is_last)
                    report_mismatch($sformatf("is_last %0b want %0b",
                                              o_rsp.is_last, e.is_last));
                if (o_rsp.status !== e.status)
                    report_mismatch($sformatf("status %0d want %0d",
                                              o_rsp.status, e.status));
                if (o_rsp.length !== e.length)
                    report_mismatch($sformatf("length %0d want %0d",
                                              o_rsp.length, e.length));
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout");
            $display("TEST FAILED");
            $finish;
        end
    end

    // Field extremes, every radix edge, zero value and capacity edges.
    task automatic test_directed();
        send_request(64'd0, 6'd10, 7'd1);
        send_request(64'd0, 6'd2, 7'd0);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 7'd64);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 7'd127);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 7'd63);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 7'd64);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 7'd16);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 7'd15);
        send_request(64'd35, 6'd36, 7'd1);
        send_request(64'd12345, 6'd10, 7'd5);
        send_request(64'd9, 6'd10, 7'd1);
        send_request(64'd5, 6'd0, 7'd64);
        send_request(64'd5, 6'd1, 7'd64);
        send_request(64'd5, 6'd37, 7'd64);
        send_request(64'd5, 6'd63, 7'd0);   // radix check wins over capacity
        send_request(64'h8000_0000_0000_0000, 6'd3, 7'd100);
        send_request(64'd1, 6'd2, 7'd0);
    endtask

    // Random requests, mostly valid radix and fitting capacity.
    task automatic test_random();
        logic [63:0] v;
        logic [5:0]  rdx;
        logic [6:0]  cap;
        for (int n = 0; n < 155; n++) begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: v = v >> $urandom_range(0, 63);
                1: v = v & 64'hFF;
                default: ;
            endcase
            // binary is slow in the divider; keep it rare
            rdx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(3, 36));
            cap = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(64, 127));
            send_request(v, rdx, cap);
        end
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        i_valid = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        i_valid <= 1'b0;
        while (digit_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/rdf_pkg.sv
hw/rtl/rdf_front.sv
hw/rtl/rdf_back.sv
hw/rtl/radix_digit_formatter.sv
sim/radix_digit_formatter_tb.sv
